### sv/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg: shared definitions for the min-heap priority queue
// Sizes, status codes, request kinds and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int CAPACITY   = 64;
   localparam int PRIO_BITS  = 16;
   localparam int TAG_BITS   = 16;

   localparam int ADDR_BITS  = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   // wide enough for the right child of the last slot
   localparam int CHILD_BITS = ADDR_BITS + 2;
   localparam int ENTRY_BITS = PRIO_BITS + TAG_BITS;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [PRIO_BITS-1:0] prio;
      logic [TAG_BITS-1:0]  tag;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic set_err;
      logic ins_start;
      logic rm_start;
      logic rm_load;
      logic dn_read;
      logic write_moving;
      logic up_step;
      logic dn_step;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_remove;
      logic is_full;
      logic is_empty;
      logic at_root;
      logic up_stop;
      logic leaf;
      logic dn_done;
   } dp_status_type;

endpackage

### sv/mhpq_req_if.sv
// ----------------------------------------------------------------------------
// mhpq_req_if: request channel
// Valid/ready channel carrying one insert or remove request.
// ----------------------------------------------------------------------------
interface mhpq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic signed [mhpq_pkg::PRIO_BITS-1:0] priority_req;
   logic [mhpq_pkg::TAG_BITS-1:0]         payload;

   modport source (output valid, output kind, output priority_req, output payload,
                   input ready);
   modport sink (input valid, input kind, input priority_req, input payload,
                 output ready);
endinterface

### sv/mhpq_rsp_if.sv
// ----------------------------------------------------------------------------
// mhpq_rsp_if: response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface mhpq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mhpq_pkg::TAG_BITS-1:0] out_payload;
   logic [1:0]                    status;
   logic [mhpq_pkg::CNT_BITS-1:0] occupancy;

   modport source (output valid, output out_payload, output status, output occupancy,
                   input ready);
   modport sink (input valid, input out_payload, input status, input occupancy,
                 output ready);
endinterface

### sv/min_heap_priority_queue_core.sv
// ----------------------------------------------------------------------------
// min_heap_priority_queue_core: binary min-heap priority queue
// Insert and remove-minimum on a heap of (priority, payload) entries.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives one response carrying the
// removed payload (zero for inserts and errors), a status and the occupancy
// afterward. The heap lives in a memory with one write and two registered
// read ports, and each tree level takes a read step and a compare/write
// step. An insert climbs from the new last slot, a remove sinks from the
// root, and a remove on empty or an insert on full goes straight to the
// response. With 64 entries the tree has seven levels, so an item climbs or
// sinks at most six levels. A new request is taken from the cycle after a
// response is posted, even while that response still waits; a finished item
// then holds in its last state until the response register is free.
module min_heap_priority_queue_core (
   input logic          clock,
   input logic          reset,
   mhpq_req_if.sink     req_chan,
   mhpq_rsp_if.source   rsp_chan
);

   mhpq_pkg::cmd_type       cmd;
   mhpq_pkg::dp_status_type dp_status;

   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   mhpq_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_kind      (req_chan.kind),
      .req_prio      (req_chan.priority_req),
      .req_tag       (req_chan.payload),
      .cmd           (cmd),
      .dp_status     (dp_status),
      .rsp_payload   (rsp_chan.out_payload),
      .rsp_status    (rsp_chan.status),
      .rsp_occupancy (rsp_chan.occupancy)
   );

`ifndef ASSERT_OFF
   // busy right after a transaction is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while a sift was pending");

   a_occupancy_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.occupancy <= mhpq_pkg::CNT_BITS'(mhpq_pkg::CAPACITY)))
      else $error("occupancy beyond capacity");

   a_full_only_at_capacity: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == mhpq_pkg::STATUS_FULL)
      |-> (rsp_chan.occupancy == mhpq_pkg::CNT_BITS'(mhpq_pkg::CAPACITY)))
      else $error("full status with room left");

   a_empty_only_at_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == mhpq_pkg::STATUS_EMPTY)
      |-> (rsp_chan.occupancy == '0 && rsp_chan.out_payload == '0))
      else $error("empty status on a non-empty queue");
`endif

endmodule

### sv/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram: generic memory
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### sv/mhpq_datapath.sv
// ----------------------------------------------------------------------------
// mhpq_datapath: heap storage and sift datapath
// Holds the entry being sifted, its slot, the fill count, the heap memory
// and the response registers; reports compare results to the controller.
// ----------------------------------------------------------------------------
module mhpq_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_kind,
   input  logic [mhpq_pkg::PRIO_BITS-1:0] req_prio,
   input  logic [mhpq_pkg::TAG_BITS-1:0]  req_tag,
   input  mhpq_pkg::cmd_type             cmd,
   output mhpq_pkg::dp_status_type       dp_status,
   output logic [mhpq_pkg::TAG_BITS-1:0]  rsp_payload,
   output logic [1:0]                    rsp_status,
   output logic [mhpq_pkg::CNT_BITS-1:0]  rsp_occupancy
);

   mhpq_pkg::entry_type                moving_ff, moving_in;
   logic [mhpq_pkg::ADDR_BITS-1:0]     pos_ff, pos_in;
   logic [mhpq_pkg::CNT_BITS-1:0]      count_ff, count_in;
   logic                               kind_ff, kind_in;
   mhpq_pkg::status_type               status_ff, status_in;
   logic [mhpq_pkg::TAG_BITS-1:0]      out_tag_ff, out_tag_in;
   logic [mhpq_pkg::TAG_BITS-1:0]      rsp_payload_ff, rsp_payload_in;
   mhpq_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [mhpq_pkg::CNT_BITS-1:0]      rsp_occ_ff, rsp_occ_in;

   logic                               wr_en;
   logic [mhpq_pkg::ADDR_BITS-1:0]     wr_addr, rd_addr_a, rd_addr_b;
   mhpq_pkg::entry_type                wr_data, rd_a, rd_b;
   logic [mhpq_pkg::ENTRY_BITS-1:0]    rd_data_a, rd_data_b;

   logic [mhpq_pkg::ADDR_BITS-1:0]     parent_idx, last_idx;
   logic [mhpq_pkg::CHILD_BITS-1:0]    left_idx, right_idx, count_ext;
   logic                               a_lt_moving, right_valid, take_right;
   logic [mhpq_pkg::PRIO_BITS-1:0]     best_prio;

   mhpq_ram #(
      .WIDTH (mhpq_pkg::ENTRY_BITS),
      .DEPTH (mhpq_pkg::CAPACITY)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign rd_a = mhpq_pkg::entry_type'(rd_data_a);
   assign rd_b = mhpq_pkg::entry_type'(rd_data_b);

   assign parent_idx = mhpq_pkg::ADDR_BITS'((pos_ff - mhpq_pkg::ADDR_BITS'(1)) >> 1);
   assign last_idx   = mhpq_pkg::ADDR_BITS'(count_ff - mhpq_pkg::CNT_BITS'(1));
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + mhpq_pkg::CHILD_BITS'(1);
   assign count_ext  = mhpq_pkg::CHILD_BITS'(count_ff);

   // port a holds the parent when climbing and the left child when sinking
   assign a_lt_moving = $signed(rd_a.prio) < $signed(moving_ff.prio);
   assign best_prio   = a_lt_moving ? rd_a.prio : moving_ff.prio;
   assign right_valid = right_idx < count_ext;
   assign take_right  = right_valid && ($signed(rd_b.prio) < $signed(best_prio));

   assign dp_status.is_remove = (kind_ff == mhpq_pkg::KIND_REMOVE);
   assign dp_status.is_full   = (count_ff == mhpq_pkg::CNT_BITS'(mhpq_pkg::CAPACITY));
   assign dp_status.is_empty  = (count_ff == '0);
   assign dp_status.at_root   = (pos_ff == '0);
   assign dp_status.up_stop   = a_lt_moving;
   assign dp_status.leaf      = (left_idx >= count_ext);
   assign dp_status.dn_done   = !a_lt_moving && !take_right;

   always_comb begin
      moving_in      = moving_ff;
      pos_in         = pos_ff;
      count_in       = count_ff;
      kind_in        = kind_ff;
      status_in      = status_ff;
      out_tag_in     = out_tag_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_occ_in     = rsp_occ_ff;
      wr_en          = 1'b0;
      wr_addr        = pos_ff;
      wr_data        = moving_ff;
      rd_addr_a      = parent_idx;
      rd_addr_b      = mhpq_pkg::ADDR_BITS'(right_idx);

      if (cmd.capture) begin
         moving_in.prio = req_prio;
         moving_in.tag  = req_tag;
         kind_in        = req_kind;
         status_in      = mhpq_pkg::STATUS_OK;
         out_tag_in     = '0;
      end
      if (cmd.set_err) begin
         if (kind_ff == mhpq_pkg::KIND_REMOVE) begin
            status_in = mhpq_pkg::STATUS_EMPTY;
         end else begin
            status_in = mhpq_pkg::STATUS_FULL;
         end
      end
      if (cmd.ins_start) begin
         pos_in   = mhpq_pkg::ADDR_BITS'(count_ff);
         count_in = count_ff + mhpq_pkg::CNT_BITS'(1);
      end
      if (cmd.rm_start) begin
         rd_addr_a = '0;
         rd_addr_b = last_idx;
         pos_in    = '0;
         count_in  = count_ff - mhpq_pkg::CNT_BITS'(1);
      end
      if (cmd.rm_load) begin
         out_tag_in = rd_a.tag;
         moving_in  = rd_b;
      end
      if (cmd.dn_read) begin
         rd_addr_a = mhpq_pkg::ADDR_BITS'(left_idx);
         rd_addr_b = mhpq_pkg::ADDR_BITS'(right_idx);
      end
      if (cmd.write_moving) begin
         wr_en = 1'b1;
      end
      if (cmd.up_step) begin
         // parent moves down into the hole, hole moves up
         wr_en   = 1'b1;
         wr_data = rd_a;
         pos_in  = parent_idx;
      end
      if (cmd.dn_step) begin
         wr_en   = 1'b1;
         wr_data = take_right ? rd_b : rd_a;
         pos_in  = take_right ? mhpq_pkg::ADDR_BITS'(right_idx)
                              : mhpq_pkg::ADDR_BITS'(left_idx);
      end
      if (cmd.rsp_load) begin
         rsp_payload_in = out_tag_ff;
         rsp_status_in  = status_ff;
         rsp_occ_in     = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      moving_ff      <= moving_in;
      pos_ff         <= pos_in;
      kind_ff        <= kind_in;
      status_ff      <= status_in;
      out_tag_ff     <= out_tag_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   assign rsp_payload   = rsp_payload_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

### sv/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// mhpq_ctrl: queue controller
// Sequences insert/sift-up and remove/sift-down and owns the handshakes.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   input  mhpq_pkg::dp_status_type dp_status,
   output mhpq_pkg::cmd_type       cmd
);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_DECIDE  = 8'b0000_0010,
      ST_UP_RD   = 8'b0000_0100,
      ST_UP_CMP  = 8'b0000_1000,
      ST_RM_LOAD = 8'b0001_0000,
      ST_DN_RD   = 8'b0010_0000,
      ST_DN_CMP  = 8'b0100_0000,
      ST_FINISH  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (dp_status.is_remove) begin
               if (dp_status.is_empty) begin
                  cmd.set_err = 1'b1;
                  state_in    = ST_FINISH;
               end else begin
                  cmd.rm_start = 1'b1;
                  state_in     = ST_RM_LOAD;
               end
            end else begin
               if (dp_status.is_full) begin
                  cmd.set_err = 1'b1;
                  state_in    = ST_FINISH;
               end else begin
                  cmd.ins_start = 1'b1;
                  state_in      = ST_UP_RD;
               end
            end
         end
         ST_UP_RD: begin
            // parent read is issued here by default
            if (dp_status.at_root) begin
               cmd.write_moving = 1'b1;
               state_in         = ST_FINISH;
            end else begin
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (dp_status.up_stop) begin
               cmd.write_moving = 1'b1;
               state_in         = ST_FINISH;
            end else begin
               cmd.up_step = 1'b1;
               state_in    = ST_UP_RD;
            end
         end
         ST_RM_LOAD: begin
            cmd.rm_load = 1'b1;
            state_in    = ST_DN_RD;
         end
         ST_DN_RD: begin
            if (dp_status.leaf) begin
               cmd.write_moving = 1'b1;
               state_in         = ST_FINISH;
            end else begin
               cmd.dn_read = 1'b1;
               state_in    = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            if (dp_status.dn_done) begin
               cmd.write_moving = 1'b1;
               state_in         = ST_FINISH;
            end else begin
               cmd.dn_step = 1'b1;
               state_in    = ST_DN_RD;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### test/min_heap_priority_queue_checker.sv
// ----------------------------------------------------------------------------
// min_heap_priority_queue_checker: response checker for the heap queue
// Watches both channels, keeps its own copy of the heap, predicts the
// response of each accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_checker (
   input  logic   clock,
   input  logic   reset,
   mhpq_req_if    req,
   mhpq_rsp_if    rsp,
   output int     pending_count,
   output int     fail_count
);

   typedef struct {
      logic [mhpq_pkg::TAG_BITS-1:0] payload;
      mhpq_pkg::status_type          status;
      logic [mhpq_pkg::CNT_BITS-1:0] occupancy;
   } queue_result_type;

   logic signed [mhpq_pkg::PRIO_BITS-1:0] heap_prio [mhpq_pkg::CAPACITY];
   logic [mhpq_pkg::TAG_BITS-1:0]         heap_tag  [mhpq_pkg::CAPACITY];
   int                                    heap_fill;

   queue_result_type expected_results [$];
   queue_result_type oldest;

   function automatic void swap_entries(int a, int b);
      logic signed [mhpq_pkg::PRIO_BITS-1:0] p;
      logic [mhpq_pkg::TAG_BITS-1:0]         t;
      p = heap_prio[a];
      t = heap_tag[a];
      heap_prio[a] = heap_prio[b];
      heap_tag[a]  = heap_tag[b];
      heap_prio[b] = p;
      heap_tag[b]  = t;
   endfunction

   function automatic queue_result_type pq_apply(logic kind,
                                                 logic signed [mhpq_pkg::PRIO_BITS-1:0] prio,
                                                 logic [mhpq_pkg::TAG_BITS-1:0] tag);
      queue_result_type res;
      int pos;
      int up;
      int best;
      res.payload = '0;
      res.status  = mhpq_pkg::STATUS_OK;
      if (kind == mhpq_pkg::KIND_INSERT) begin
         if (heap_fill >= mhpq_pkg::CAPACITY) begin
            res.status = mhpq_pkg::STATUS_FULL;
         end else begin
            heap_prio[heap_fill] = prio;
            heap_tag[heap_fill]  = tag;
            pos = heap_fill;
            heap_fill++;
            // equal priorities keep climbing
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (heap_prio[up] < heap_prio[pos]) break;
               swap_entries(pos, up);
               pos = up;
            end
         end
      end else begin
         if (heap_fill == 0) begin
            res.status = mhpq_pkg::STATUS_EMPTY;
         end else begin
            res.payload = heap_tag[0];
            heap_fill--;
            heap_prio[0] = heap_prio[heap_fill];
            heap_tag[0]  = heap_tag[heap_fill];
            pos = 0;
            while (pos < heap_fill) begin
               best = pos;
               if (2 * pos + 1 < heap_fill && heap_prio[2 * pos + 1] < heap_prio[best])
                  best = 2 * pos + 1;
               if (2 * pos + 2 < heap_fill && heap_prio[2 * pos + 2] < heap_prio[best])
                  best = 2 * pos + 2;
               if (best == pos) break;
               swap_entries(pos, best);
               pos = best;
            end
         end
      end
      res.occupancy = mhpq_pkg::CNT_BITS'(heap_fill);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         heap_fill  = 0;
         fail_count = 0;
         expected_results.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               $error("response transaction with no request outstanding");
               fail_count++;
            end else begin
               oldest = expected_results.pop_front();
               if (rsp.out_payload !== oldest.payload) begin
                  $error("out_payload mismatch: expected %h, actual %h",
                         oldest.payload, rsp.out_payload);
                  fail_count++;
               end
               if (rsp.status !== oldest.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         oldest.status, rsp.status);
                  fail_count++;
               end
               if (rsp.occupancy !== oldest.occupancy) begin
                  $error("occupancy mismatch: expected %0d, actual %0d",
                         oldest.occupancy, rsp.occupancy);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready)
            expected_results = {expected_results,
                                pq_apply(req.kind, req.priority_req, req.payload)};
      end
      pending_count = expected_results.size();
   end

endmodule

### test/tb_min_heap_priority_queue_core.sv
// ----------------------------------------------------------------------------
// tb_min_heap_priority_queue_core: testbench for the heap priority queue
// Directed corner requests, then random insert/remove mixes that fill the
// heap and drain it again under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_min_heap_priority_queue_core;

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   pending_count;
   int   fail_count;

   mhpq_req_if req_if ();
   mhpq_rsp_if rsp_if ();

   min_heap_priority_queue_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   min_heap_priority_queue_checker heap_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_if),
      .rsp           (rsp_if),
      .pending_count (pending_count),
      .fail_count    (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 1000000);
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic signed [mhpq_pkg::PRIO_BITS-1:0] rand_priority();
      int pick;
      int v;
      pick = $urandom_range(99);
      if (pick < 50) begin
         v = $urandom_range(65535);
      end else if (pick < 80) begin
         // narrow range so ties are common
         v = $urandom_range(8) - 4;
      end else begin
         case ($urandom_range(3))
            0: v = -32768;
            1: v = -32767;
            2: v = 32767;
            default: v = 32766;
         endcase
      end
      return mhpq_pkg::PRIO_BITS'(v);
   endfunction

   task automatic send_request(input logic kind,
                               input logic signed [mhpq_pkg::PRIO_BITS-1:0] prio,
                               input logic [mhpq_pkg::TAG_BITS-1:0] tag);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.kind         <= kind;
      req_if.priority_req <= prio;
      req_if.payload      <= tag;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_random(input int insert_pct);
      if ($urandom_range(99) < insert_pct)
         send_request(mhpq_pkg::KIND_INSERT, rand_priority(),
                      mhpq_pkg::TAG_BITS'($urandom_range(65535)));
      else
         send_request(mhpq_pkg::KIND_REMOVE, rand_priority(),
                      mhpq_pkg::TAG_BITS'($urandom_range(65535)));
   endtask

   // hold the sender until every response has been taken
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int idle_set  [4];
      int stall_set [4];
      int mix_set   [3];
      int len_set   [3];
      idle_set  = '{0, 72, 0, 32};
      stall_set = '{0, 0, 72, 32};
      mix_set   = '{85, 15, 50};
      len_set   = '{120, 120, 110};

      reset               = 1'b1;
      idle_pct            = 0;
      stall_pct           = 0;
      req_if.valid        = 1'b0;
      req_if.kind         = mhpq_pkg::KIND_INSERT;
      req_if.priority_req = '0;
      req_if.payload      = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners: empty remove, extreme priorities and payloads, ties
      send_request(mhpq_pkg::KIND_REMOVE, 16'sd0, 16'h0000);
      send_request(mhpq_pkg::KIND_INSERT, 16'sd32767, 16'h0000);
      send_request(mhpq_pkg::KIND_INSERT, -16'sd32768, 16'hffff);
      send_request(mhpq_pkg::KIND_INSERT, 16'sd0, 16'h1234);
      send_request(mhpq_pkg::KIND_INSERT, -16'sd1, 16'h8000);
      send_request(mhpq_pkg::KIND_INSERT, 16'sd0, 16'h0001);
      send_request(mhpq_pkg::KIND_INSERT, 16'sd0, 16'h0002);
      send_request(mhpq_pkg::KIND_INSERT, 16'sd32767, 16'h5555);
      send_request(mhpq_pkg::KIND_INSERT, -16'sd32768, 16'haaaa);
      repeat (8) send_request(mhpq_pkg::KIND_REMOVE, -16'sd1, 16'hffff);
      send_request(mhpq_pkg::KIND_REMOVE, 16'sd0, 16'h0000);
      drain_responses();

      // each phase fills toward full, drains past empty, then mixes
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = idle_set[ph];
         stall_pct = stall_set[ph];
         for (int blk = 0; blk < 3; blk++)
            repeat (len_set[blk]) send_random(mix_set[blk]);
         drain_responses();
      end

      idle_pct  = 0;
      stall_pct = 0;
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
